### src/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

   // queue depth and counter sizing
   localparam int CAPACITY = 1024;
   localparam int KEY_W    = 32;
   localparam int OCC_W    = 11;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int CNT_W    = (CNT_BITS > OCC_W) ? CNT_BITS : OCC_W;

   typedef enum logic [0:0] {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // request word
   typedef struct packed {
      op_type             operation;
      logic [KEY_W-1:0]   value;
   } req_type;

   // response word
   typedef struct packed {
      logic [KEY_W-1:0]   min_value;
      status_type         status;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   // command broadcast to every cell
   typedef struct packed {
      logic               insert;
      logic               extract;
      logic [KEY_W-1:0]   key;
   } cmd_type;

endpackage

### src/mhpq_cell.sv
`timescale 1ns / 1ps

module mhpq_cell (
   input  logic                       clock,
   input  mhpq_pkg::cmd_type          cmd,
   input  logic                       self_valid,
   input  logic [mhpq_pkg::KEY_W-1:0] left_key,
   input  logic                       left_take,
   input  logic [mhpq_pkg::KEY_W-1:0] right_key,
   output logic [mhpq_pkg::KEY_W-1:0] key,
   output logic                       take
);

   logic [mhpq_pkg::KEY_W-1:0] key_ff;
   logic [mhpq_pkg::KEY_W-1:0] key_in;

   // new key goes at or before this cell when it is smaller or the cell is empty
   assign take = cmd.insert && (!self_valid || ($signed(cmd.key) < $signed(key_ff)));

   // shift right on insert, shift left on extract
   always_comb begin
      key_in = key_ff;
      if (take) begin
         key_in = left_take ? left_key : cmd.key;
      end else if (cmd.extract) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

### src/min_heap_priority_queue.sv
`timescale 1ns / 1ps

// channel    ports                          direction  word
// request    start, busy, req_data          in         operation, value
// response   rsp_strobe, rsp_data           out        min_value, status, occupancy
//
// keys sit sorted in a row of cells, smallest at the head; every cell compares
// the broadcast key, and each cell that shifts moves its entry one place.
// one word is taken per cycle; its response shows in the cycle after acceptance.
// busy stays low; the response cycle never blocks the next request.
// reset empties the queue by clearing the entry count; cell contents are kept.
// the receiver cannot stall: each response is valid for exactly one cycle.

module min_heap_priority_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mhpq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output mhpq_pkg::rsp_type rsp_data
);

   localparam int N = mhpq_pkg::CAPACITY;

   logic [mhpq_pkg::CNT_W-1:0] count_ff;
   logic [mhpq_pkg::CNT_W-1:0] count_in;
   logic                       rsp_strobe_ff;
   mhpq_pkg::rsp_type          rsp_data_ff;
   mhpq_pkg::rsp_type          rsp_data_in;

   logic                       accept;
   logic                       full;
   logic                       empty;
   mhpq_pkg::cmd_type          cmd;

   logic [mhpq_pkg::KEY_W-1:0] keys  [N];
   logic                       takes [N];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == mhpq_pkg::CNT_W'(N));
   assign empty  = (count_ff == '0);

   // command seen by all cells, refused operations leave the row alone
   always_comb begin
      cmd.insert  = accept && (req_data.operation == mhpq_pkg::OP_INSERT) && !full;
      cmd.extract = accept && (req_data.operation == mhpq_pkg::OP_EXTRACT) && !empty;
      cmd.key     = req_data.value;
   end

   // row of cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      localparam logic [mhpq_pkg::CNT_W-1:0] IDX = mhpq_pkg::CNT_W'(i);
      logic [mhpq_pkg::KEY_W-1:0] lkey;
      logic                       ltake;
      logic [mhpq_pkg::KEY_W-1:0] rkey;

      if (i == 0) begin : g_head
         assign lkey  = '0;
         assign ltake = 1'b0;
      end else begin : g_body
         assign lkey  = keys[i-1];
         assign ltake = takes[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign rkey = keys[i];
      end else begin : g_inner
         assign rkey = keys[i+1];
      end

      mhpq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .self_valid (IDX < count_ff),
         .left_key   (lkey),
         .left_take  (ltake),
         .right_key  (rkey),
         .key        (keys[i]),
         .take       (takes[i])
      );
   end

   // entry count and response word
   always_comb begin
      count_in              = count_ff;
      rsp_data_in.min_value = '0;
      rsp_data_in.status    = mhpq_pkg::STATUS_OK;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.extract) begin
         count_in              = count_ff - 1'b1;
         rsp_data_in.min_value = keys[0];
      end else if (accept && (req_data.operation == mhpq_pkg::OP_INSERT)) begin
         rsp_data_in.status = mhpq_pkg::STATUS_FULL;
      end else if (accept) begin
         rsp_data_in.status = mhpq_pkg::STATUS_EMPTY;
      end
      rsp_data_in.occupancy = count_in[mhpq_pkg::OCC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mhpq_pkg::CNT_W'(N))
      else $error("entry count above capacity");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe_ff)
      else $error("accepted word produced no response");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= mhpq_pkg::CNT_W'(2)) |-> ($signed(keys[0]) <= $signed(keys[1])))
      else $error("head of the row out of order");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the count");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int NO_GAP_WORDS   = 400;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   mhpq_pkg::req_type req_data;
   logic              rsp_strobe;
   mhpq_pkg::rsp_type rsp_data;

   // shadow heap, updated at each accepted request word
   logic [mhpq_pkg::KEY_W-1:0] heap_mem [mhpq_pkg::CAPACITY];
   int                         heap_count;

   mhpq_pkg::rsp_type expected_rsp [$];
   mhpq_pkg::rsp_type head_rsp;

   int  mismatch_count;
   int  idle_cycles;
   int  insert_count;
   int  extract_count;
   int  full_refusals;
   int  empty_refusals;
   int  peak_occupancy;
   bit  gaps_on;

   min_heap_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // heap behavior: sift up on insert, sift down on extract, ties go right
   function automatic mhpq_pkg::rsp_type apply_to_heap(input mhpq_pkg::req_type w);
      mhpq_pkg::rsp_type          r;
      int                         pos;
      int                         up;
      int                         lc;
      int                         rc;
      int                         pick;
      logic [mhpq_pkg::KEY_W-1:0] t;
      r = '0;
      r.status = mhpq_pkg::STATUS_OK;
      if (w.operation == mhpq_pkg::OP_INSERT) begin
         if (heap_count >= mhpq_pkg::CAPACITY) begin
            r.status = mhpq_pkg::STATUS_FULL;
            full_refusals++;
         end else begin
            heap_mem[heap_count] = w.value;
            pos = heap_count;
            while (pos != 0) begin
               up = (pos - 1) / 2;
               if ($signed(heap_mem[up]) < $signed(heap_mem[pos])) break;
               t = heap_mem[up];
               heap_mem[up] = heap_mem[pos];
               heap_mem[pos] = t;
               pos = up;
            end
            heap_count++;
            insert_count++;
         end
      end else begin
         if (heap_count == 0) begin
            r.status = mhpq_pkg::STATUS_EMPTY;
            empty_refusals++;
         end else begin
            r.min_value = heap_mem[0];
            heap_count--;
            heap_mem[0] = heap_mem[heap_count];
            pos = 0;
            while (2 * pos + 1 < heap_count) begin
               lc = 2 * pos + 1;
               rc = lc + 1;
               pick = lc;
               if (rc < heap_count && !($signed(heap_mem[lc]) < $signed(heap_mem[rc])))
                  pick = rc;
               if ($signed(heap_mem[pos]) < $signed(heap_mem[pick])) break;
               t = heap_mem[pos];
               heap_mem[pos] = heap_mem[pick];
               heap_mem[pick] = t;
               pos = pick;
            end
            extract_count++;
         end
      end
      if (heap_count > peak_occupancy) peak_occupancy = heap_count;
      r.occupancy = heap_count[mhpq_pkg::OCC_W-1:0];
      return r;
   endfunction

   // keys: full range, a narrow band for ties, or the extremes
   function automatic logic [mhpq_pkg::KEY_W-1:0] random_key();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 15) - 8;
         1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // drive one request word and wait until it is taken
   task automatic send_word(input mhpq_pkg::op_type op,
                            input logic [mhpq_pkg::KEY_W-1:0] key);
      mhpq_pkg::req_type w;
      w.operation = op;
      w.value = key;
      if (gaps_on)
         while ($urandom_range(0, 99) < 19) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      expected_rsp.push_back(apply_to_heap(w));
   endtask

   // refusals, extreme keys, duplicates, then empty the queue again
   task automatic test_directed();
      send_word(mhpq_pkg::OP_EXTRACT, 32'hffff_ffff);
      send_word(mhpq_pkg::OP_INSERT, 32'h7fff_ffff);
      send_word(mhpq_pkg::OP_INSERT, 32'h8000_0000);
      send_word(mhpq_pkg::OP_INSERT, 32'h0000_0000);
      send_word(mhpq_pkg::OP_INSERT, 32'hffff_ffff);
      send_word(mhpq_pkg::OP_INSERT, 32'h0000_0001);
      send_word(mhpq_pkg::OP_INSERT, 32'h0000_0005);
      send_word(mhpq_pkg::OP_INSERT, 32'h0000_0005);
      send_word(mhpq_pkg::OP_INSERT, 32'h0000_0005);
      send_word(mhpq_pkg::OP_INSERT, 32'h8000_0000);
      send_word(mhpq_pkg::OP_INSERT, 32'h7fff_ffff);
      send_word(mhpq_pkg::OP_EXTRACT, 32'h5555_5555);
      send_word(mhpq_pkg::OP_INSERT, 32'h8000_0001);
      while (heap_count > 0)
         send_word(mhpq_pkg::OP_EXTRACT, 32'haaaa_aaaa);
      send_word(mhpq_pkg::OP_EXTRACT, 32'h0000_0000);
      send_word(mhpq_pkg::OP_EXTRACT, 32'h7fff_ffff);
   endtask

   // mixed traffic with random gaps
   task automatic test_random_mix(input int n_words);
      mhpq_pkg::op_type op;
      for (int i = 0; i < n_words; i++) begin
         if (heap_count == 0)
            op = ($urandom_range(0, 9) == 0) ? mhpq_pkg::OP_EXTRACT : mhpq_pkg::OP_INSERT;
         else
            op = ($urandom_range(0, 99) < 55) ? mhpq_pkg::OP_INSERT : mhpq_pkg::OP_EXTRACT;
         send_word(op, random_key());
      end
   endtask

   // fill to capacity with a long gapless stretch first, push against the
   // full heap, then take some words back out
   task automatic test_fill_to_full();
      int n;
      n = 0;
      while (heap_count < mhpq_pkg::CAPACITY) begin
         gaps_on = (n >= NO_GAP_WORDS);
         send_word(mhpq_pkg::OP_INSERT, random_key());
         n++;
      end
      gaps_on = 1'b1;
      send_word(mhpq_pkg::OP_INSERT, 32'h8000_0000);
      send_word(mhpq_pkg::OP_INSERT, 32'h7fff_ffff);
      send_word(mhpq_pkg::OP_INSERT, $urandom);
      for (int i = 0; i < 20; i++)
         send_word((i % 2 == 0) ? mhpq_pkg::OP_EXTRACT : mhpq_pkg::OP_INSERT, random_key());
      send_word(mhpq_pkg::OP_INSERT, $urandom);
      for (int i = 0; i < 30; i++)
         send_word(mhpq_pkg::OP_EXTRACT, $urandom);
   endtask

   // response checker against the oldest expected word
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            head_rsp = expected_rsp.pop_front();
            if (rsp_data.min_value !== head_rsp.min_value)
               report_mismatch($sformatf("min_value %0d, expected %0d",
                  $signed(rsp_data.min_value), $signed(head_rsp.min_value)));
            if (rsp_data.status !== head_rsp.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                  rsp_data.status, head_rsp.status));
            if (rsp_data.occupancy !== head_rsp.occupancy)
               report_mismatch($sformatf("occupancy %0d, expected %0d",
                  rsp_data.occupancy, head_rsp.occupancy));
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d words outstanding", expected_rsp.size());
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      heap_count = 0;
      mismatch_count = 0;
      idle_cycles = 0;
      insert_count = 0;
      extract_count = 0;
      full_refusals = 0;
      empty_refusals = 0;
      peak_occupancy = 0;
      gaps_on = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(40);
      test_fill_to_full();

      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("expected words left over");

      $display("covered %0d inserts and %0d extracts, peak occupancy %0d",
         insert_count, extract_count, peak_occupancy);
      $display("refused %0d inserts when full, %0d extracts when empty; %0d mismatches",
         full_refusals, empty_refusals, mismatch_count);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### filelist.f
src/mhpq_pkg.sv
src/mhpq_cell.sv
src/min_heap_priority_queue.sv
test/tb.sv
